// ===== design/spe_pkg.sv =====
package spe_pkg;

  localparam int unsigned LogSteps  = 24;
  localparam int unsigned DivStages = 4;

  localparam logic [19:0] PsMax    = 20'hFFFFF;
  localparam logic [39:0] DivRecip = 40'((64'd1 << 47) / 64'd141 + 64'd1);

  typedef struct packed {
    logic [19:0] psl;
    logic        last;
    logic        derr;
  } side_t;

  typedef struct packed {
    logic [4:0]  pn;
    logic [4:0]  pd;
    logic [31:0] mn;
    logic [31:0] md;
    logic [23:0] fn;
    logic [23:0] fd;
    side_t       side;
  } log_t;

  typedef struct packed {
    logic signed [7:0] ip;
    logic [23:0]       f;
    logic [30:0]       m;
    side_t             side;
  } exp_t;

  function automatic logic [31:0] isqrt62(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bit_w;
    v     = v_in;
    res   = 64'd0;
    bit_w = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bit_w) begin
        v   = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res[31:0];
  endfunction

  // Q30 value of 2 to the power of 2^-k, built by repeated truncated square roots.
  function automatic logic [30:0] exp_coef(input int k);
    logic [63:0] c;
    c = 64'd2 << 30;
    for (int i = 1; i <= k; i++) begin
      c = {32'd0, isqrt62(c << 30)};
    end
    return c[30:0];
  endfunction

  function automatic logic [4:0] lead_pos(input logic [26:0] x);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 27; i++) begin
      if (x[i]) begin
        p = 5'(i);
      end
    end
    return p;
  endfunction

endpackage

// ===== design/surface_pressure_estimate.sv =====
// Channel | Direction | Handshake              | Word
// input   | in        | in_valid_i, in_stall_o  | temperature, sea level pressure, elevation, last
// output  | out       | out_valid_o, out_stall_i| surface pressure, domain error, saturated, last
//
// One word is taken every cycle unless a stalled output word freezes the pipeline.
// The pipeline holds two 24-step squaring chains, a four-stage block that scales by 500 and
// divides by 141 through a reciprocal multiply, and a 24-step chain of constant multiplies.
// Reset clears only the valid bits of the pipeline.
// A stalled output word freezes the whole pipeline and stalls the input in the same cycle.
module surface_pressure_estimate (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [15:0]         temperature_i,
  input  logic [19:0]         sea_level_pressure_i,
  input  logic signed [14:0]  elevation_i,
  input  logic                last_point_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [19:0]         surface_pressure_o,
  output logic                domain_error_o,
  output logic                saturated_o,
  output logic                last_out_o
);
  import spe_pkg::*;

  localparam int unsigned Lat = 2 * LogSteps + DivStages + 6;

  logic [Lat-1:0] vld_q;
  logic           adv;

  assign adv        = !(vld_q[Lat-1] && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  logic [25:0]        n_a;
  logic signed [25:0] ez_a;
  logic signed [27:0] d_a;
  logic [25:0]        a_n_q;
  logic signed [27:0] a_d_q;
  side_t              a_side_q;

  assign n_a  = 26'(temperature_i * 10'd800);
  assign ez_a = elevation_i * 11'sd981;
  assign d_a  = $signed({2'b00, n_a}) + {{2{ez_a[25]}}, ez_a};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_n_q         <= n_a;
      a_d_q         <= d_a;
      a_side_q.psl  <= sea_level_pressure_i;
      a_side_q.last <= last_point_i;
      a_side_q.derr <= (d_a <= 28'sd0) || (temperature_i == 16'd0);
    end
  end

  log_t lg_q [0:LogSteps];
  log_t lg_b;

  always_comb begin
    lg_b      = '0;
    lg_b.pn   = lead_pos({1'b0, a_n_q});
    lg_b.pd   = lead_pos(a_d_q[26:0]);
    lg_b.mn   = {6'd0, a_n_q} << (5'd31 - lg_b.pn);
    lg_b.md   = {5'd0, a_d_q[26:0]} << (5'd31 - lg_b.pd);
    lg_b.side = a_side_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lg_q[0] <= lg_b;
    end
  end

  for (genvar k = 0; k < LogSteps; k++) begin : g_log
    logic [63:0] sqn;
    logic [63:0] sqd;
    log_t        nx;

    always_comb begin
      sqn = 64'(lg_q[k].mn) * 64'(lg_q[k].mn);
      sqd = 64'(lg_q[k].md) * 64'(lg_q[k].md);
      nx  = lg_q[k];
      if (sqn[63]) begin
        nx.mn = sqn[63:32];
        nx.fn = {lg_q[k].fn[22:0], 1'b1};
      end else begin
        nx.mn = sqn[62:31];
        nx.fn = {lg_q[k].fn[22:0], 1'b0};
      end
      if (sqd[63]) begin
        nx.md = sqd[63:32];
        nx.fd = {lg_q[k].fd[22:0], 1'b1};
      end else begin
        nx.md = sqd[62:31];
        nx.fd = {lg_q[k].fd[22:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        lg_q[k+1] <= nx;
      end
    end
  end

  logic signed [29:0] c_q;
  side_t              c_side_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_q      <= $signed({1'b0, lg_q[LogSteps].pn, lg_q[LogSteps].fn})
                - $signed({1'b0, lg_q[LogSteps].pd, lg_q[LogSteps].fd});
      c_side_q <= lg_q[LogSteps].side;
    end
  end

  logic signed [38:0] prod_e;
  logic signed [38:0] d_prod_q;
  side_t              d_prod_side_q;

  assign prod_e = c_q * 11'sd500;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_prod_q      <= prod_e;
      d_prod_side_q <= c_side_q;
    end
  end

  // For a negative product its magnitude plus 140 is divided by 141, so that the quotient rounds down.
  logic [38:0] mag_d;
  logic [38:0] d_mag_q;
  logic        d_mag_neg_q;
  side_t       d_mag_side_q;

  assign mag_d = d_prod_q[38] ? 39'd140 - $unsigned(d_prod_q) : $unsigned(d_prod_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_mag_q      <= mag_d;
      d_mag_neg_q  <= d_prod_q[38];
      d_mag_side_q <= d_prod_side_q;
    end
  end

  logic [39:0] pp_hh_q;
  logic [39:0] pp_hl_q;
  logic [39:0] pp_lh_q;
  logic [39:0] pp_ll_q;
  logic        pp_neg_q;
  side_t       pp_side_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pp_hh_q   <= 40'(d_mag_q[38:20]) * 40'(DivRecip[39:20]);
      pp_hl_q   <= 40'(d_mag_q[38:20]) * 40'(DivRecip[19:0]);
      pp_lh_q   <= 40'(d_mag_q[19:0]) * 40'(DivRecip[39:20]);
      pp_ll_q   <= 40'(d_mag_q[19:0]) * 40'(DivRecip[19:0]);
      pp_neg_q  <= d_mag_neg_q;
      pp_side_q <= d_mag_side_q;
    end
  end

  logic [78:0] acc_w;
  logic [31:0] q_q;
  logic        q_neg_q;
  side_t       q_side_q;

  assign acc_w = (79'(pp_hh_q) << 40) + (79'(pp_hl_q) << 20) + (79'(pp_lh_q) << 20)
               + 79'(pp_ll_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      q_q      <= acc_w[78:47];
      q_neg_q  <= pp_neg_q;
      q_side_q <= pp_side_q;
    end
  end

  logic [31:0] y_w;
  exp_t        ex_q [0:LogSteps];

  assign y_w = q_neg_q ? 32'd0 - q_q : q_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ex_q[0].ip   <= $signed(y_w[31:24]);
      ex_q[0].f    <= y_w[23:0];
      ex_q[0].m    <= 31'd1 << 30;
      ex_q[0].side <= q_side_q;
    end
  end

  for (genvar k = 1; k <= LogSteps; k++) begin : g_exp
    localparam logic [30:0] Coef = exp_coef(k);
    localparam int unsigned Sel  = LogSteps - k;
    logic [61:0] pr;
    exp_t        nx;

    always_comb begin
      pr = 62'(ex_q[k-1].m) * 62'(Coef);
      nx = ex_q[k-1];
      if (ex_q[k-1].f[Sel]) begin
        nx.m = pr[60:30];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        ex_q[k] <= nx;
      end
    end
  end

  logic [50:0]       p_prod_q;
  logic signed [8:0] p_s_q;
  side_t             p_side_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_prod_q <= 51'(ex_q[LogSteps].side.psl) * 51'(ex_q[LogSteps].m);
      p_s_q    <= 9'sd30 - $signed({ex_q[LogSteps].ip[7], ex_q[LogSteps].ip});
      p_side_q <= ex_q[LogSteps].side;
    end
  end

  logic [50:0] sh_o;
  logic [19:0] res_d;
  logic        sat_d;

  assign sh_o = p_prod_q >> p_s_q[5:0];

  always_comb begin
    res_d = 20'd0;
    sat_d = 1'b0;
    if (p_side_q.derr || p_prod_q == 51'd0) begin
      res_d = 20'd0;
    end else if (p_s_q <= 9'sd0) begin
      sat_d = 1'b1;
    end else if (p_s_q >= 9'sd51) begin
      res_d = 20'd0;
    end else if (sh_o > 51'(PsMax)) begin
      sat_d = 1'b1;
    end else begin
      res_d = sh_o[19:0];
    end
    if (sat_d) begin
      res_d = PsMax;
    end
  end

  logic [19:0] o_res_q;
  logic        o_derr_q;
  logic        o_sat_q;
  logic        o_last_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_res_q  <= res_d;
      o_derr_q <= p_side_q.derr;
      o_sat_q  <= sat_d;
      o_last_q <= p_side_q.last;
    end
  end

  assign out_valid_o        = vld_q[Lat-1];
  assign surface_pressure_o = o_res_q;
  assign domain_error_o     = o_derr_q;
  assign saturated_o        = o_sat_q;
  assign last_out_o         = o_last_q;

endmodule

// ===== design/spe_checker.sv =====
module spe_assert (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [15:0]        temperature_i,
  input logic [19:0]        sea_level_pressure_i,
  input logic signed [14:0] elevation_i,
  input logic               last_point_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [19:0]        surface_pressure_o,
  input logic               domain_error_o,
  input logic               saturated_o,
  input logic               last_out_o
);
  import spe_pkg::*;

  a_derr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && domain_error_o |-> surface_pressure_o == 20'd0 && !saturated_o)
    else $error("Domain error word carries a non-zero result.");

  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> surface_pressure_o == PsMax)
    else $error("Saturated word is not at full scale.");

  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("Input stalled while the output is free.");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Output word dropped while stalled.");

  a_word_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(surface_pressure_o) && $stable(last_out_o))
    else $error("Output word changed while stalled.");

endmodule

bind surface_pressure_estimate spe_assert u_spe_assert (.*);
